>>> rtl/core/flash_record_log_store_macros.svh
// assertion helpers used by flash_record_log_store
`ifndef FLASH_RECORD_LOG_STORE_MACROS_SVH
`define FLASH_RECORD_LOG_STORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define FRLS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frls assertion failed");

// next-cycle implication, checked out of reset
`define FRLS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frls assertion failed");

`endif

>>> rtl/core/frls_pkg.sv
`timescale 1ns / 1ps

package frls_pkg;

    localparam logic [15:0] REC_MARK  = 16'hAAAA;
    localparam logic [15:0] ERASED_HW = 16'hFFFF;

    typedef struct packed {
        logic        action;
        logic [31:0] write_value;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [31:0] read_value;
        logic        page_erased;
    } rsp_t;

    typedef struct packed {
        logic        rd;
        logic        wr;
        logic        clear;
        logic [15:0] wdata;
    } page_cmd_t;

endpackage

>>> rtl/core/frls_page.sv
`timescale 1ns / 1ps

module frls_page #(
    parameter int N  = 1024,
    parameter int AW = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  frls_pkg::page_cmd_t  cmd,
    input  logic [AW-1:0]        addr,
    output logic [15:0]          rdata
);

    localparam int FW = $clog2(N + 1);

    logic [15:0]   mem [N];
    logic [15:0]   rd_data_reg;
    logic          rd_hit_reg;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] addr_ext;
    logic [FW-1:0] addr_inc;

    assign addr_ext = FW'(addr);
    assign addr_inc = addr_ext + FW'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[addr] <= cmd.wdata;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    // cells at or above the fill mark read as erased
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (cmd.rd)
            begin
                rd_hit_reg <= (addr_ext < fill_reg);
            end
            if (cmd.wr && (cmd.clear || addr_ext >= fill_reg))
            begin
                fill_reg <= addr_inc;
            end
            else if (cmd.clear)
            begin
                fill_reg <= '0;
            end
        end
    end

    assign rdata = rd_hit_reg ? rd_data_reg : frls_pkg::ERASED_HW;

endmodule

>>> rtl/core/flash_record_log_store.sv
`timescale 1ns / 1ps
// Append-only record log in one erasable page of PAGE_HALFWORDS halfwords.
// Request channel (req_valid / req_stall / req): action 0 reads the latest
// record, action 1 appends req.write_value as a new 3-halfword record.
// Response channel (rsp_valid / rsp_stall / rsp): one word per request with
// found, read_value and page_erased.
// One request is worked on at a time; req_stall is high while it runs.
// A scan reads one slot marker at a time through the page memory's single
// port, so a read or an append takes longer the more records are stored.
// An append that erases only rewinds the fill mark and needs no erase pass.
// Reset clears the fill mark: the whole page reads as erased at once and no
// clearing pass is needed; requests are taken from the first cycle.
// A finished response sits in an output register; if rsp_stall holds it,
// the next request may still be taken and scanned, and its response waits
// until the register frees up.
`include "flash_record_log_store_macros.svh"

module flash_record_log_store #(
    parameter int PAGE_HALFWORDS = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  frls_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output frls_pkg::rsp_t  rsp
);

    localparam int AW = $clog2(PAGE_HALFWORDS);
    localparam logic [AW-1:0] ERASE_AT = AW'(PAGE_HALFWORDS - 6);
    localparam logic [AW-1:0] STEP_P3  = AW'(3);
    localparam logic [AW-1:0] STEP_P1  = AW'(1);
    localparam logic [AW-1:0] STEP_M2  = ~AW'(1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;
    localparam logic [3:0] S_SCHK = 4'd2;
    localparam logic [3:0] S_RLO  = 4'd3;
    localparam logic [3:0] S_RHI  = 4'd4;
    localparam logic [3:0] S_RFIN = 4'd5;
    localparam logic [3:0] S_W0   = 4'd6;
    localparam logic [3:0] S_W1   = 4'd7;
    localparam logic [3:0] S_W2   = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0]          state_reg, state_next;
    logic [AW-1:0]       addr_reg, addr_next;
    logic [AW-1:0]       step;
    logic [AW-1:0]       addr_sum;
    logic                action_reg, action_next;
    logic [31:0]         value_reg, value_next;
    logic                erase_reg, erase_next;
    logic [15:0]         lo_reg, lo_next;
    frls_pkg::rsp_t      res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    frls_pkg::rsp_t      out_reg, out_next;
    frls_pkg::page_cmd_t cmd;
    logic [15:0]         rdata;
    logic                mark_hit;

    frls_page #(
        .N  (PAGE_HALFWORDS),
        .AW (AW)
    ) u_page (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .addr  (addr_reg),
        .rdata (rdata)
    );

    // shared address adder
    assign addr_sum = addr_reg + step;
    assign mark_hit = (rdata == frls_pkg::REC_MARK);

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // adder step: next slot on a marker hit, back to the low half on a read miss, else one halfword ahead
    always_comb
    begin
        step = STEP_P1;
        if (state_reg == S_SCHK)
        begin
            if (mark_hit)
            begin
                step = STEP_P3;
            end
            else if (!action_reg)
            begin
                step = STEP_M2;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        action_next    = action_reg;
        value_next     = value_reg;
        erase_next     = erase_reg;
        lo_next        = lo_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        cmd            = '{rd: 1'b0, wr: 1'b0, clear: 1'b0, wdata: frls_pkg::REC_MARK};

        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    action_next = req.action;
                    value_next  = req.write_value;
                    erase_next  = 1'b0;
                    addr_next   = '0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.rd     = 1'b1;
                state_next = S_SCHK;
            end
            S_SCHK:
            begin
                if (mark_hit)
                begin
                    addr_next  = addr_sum;
                    state_next = S_SCAN;
                end
                else if (!action_reg)
                begin
                    if (addr_reg != '0)
                    begin
                        // back to the low half of the latest record
                        addr_next  = addr_sum;
                        state_next = S_RLO;
                    end
                    else
                    begin
                        res_next   = '{found: 1'b0, read_value: 32'd0, page_erased: 1'b0};
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    // addr_reg already points at the slot after the latest one
                    if (addr_reg == '0 || addr_reg >= ERASE_AT)
                    begin
                        erase_next = 1'b1;
                        addr_next  = '0;
                    end
                    state_next = S_W0;
                end
            end
            S_RLO:
            begin
                cmd.rd     = 1'b1;
                addr_next  = addr_sum;
                state_next = S_RHI;
            end
            S_RHI:
            begin
                cmd.rd     = 1'b1;
                lo_next    = rdata;
                state_next = S_RFIN;
            end
            S_RFIN:
            begin
                res_next   = '{found: 1'b1, read_value: {rdata, lo_reg}, page_erased: 1'b0};
                state_next = S_DONE;
            end
            S_W0:
            begin
                cmd.wr     = 1'b1;
                cmd.clear  = erase_reg;
                cmd.wdata  = frls_pkg::REC_MARK;
                addr_next  = addr_sum;
                state_next = S_W1;
            end
            S_W1:
            begin
                cmd.wr     = 1'b1;
                cmd.wdata  = value_reg[15:0];
                addr_next  = addr_sum;
                state_next = S_W2;
            end
            S_W2:
            begin
                cmd.wr     = 1'b1;
                cmd.wdata  = value_reg[31:16];
                res_next   = '{found: 1'b1, read_value: 32'd0, page_erased: erase_reg};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        action_reg <= action_next;
        value_reg  <= value_next;
        erase_reg  <= erase_next;
        lo_reg     <= lo_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    `FRLS_ASSERT_IMP(a_wr_in_page, cmd.wr, int'(addr_reg) < PAGE_HALFWORDS)
    `FRLS_ASSERT_IMP(a_miss_is_clean, out_valid_reg && !out_reg.found, out_reg.read_value == 32'd0 && !out_reg.page_erased)
    `FRLS_ASSERT_IMP(a_erase_on_append, out_valid_reg && out_reg.page_erased, out_reg.found && out_reg.read_value == 32'd0)
    `FRLS_ASSERT_NXT(a_rsp_from_done, !out_valid_reg && state_reg != S_DONE, !out_valid_reg)

endmodule

>>> sim/frls_log_checker.sv
`timescale 1ns / 1ps

module frls_log_checker #(
    parameter int PAGE_HW = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_stall,
    input  frls_pkg::req_t req,
    input  logic           rsp_valid,
    input  logic           rsp_stall,
    input  frls_pkg::rsp_t rsp,
    output int             mismatches,
    output int             pending_words,
    output int             erase_count,
    output int             words_checked
);

    localparam int   REPORT_LIMIT = 10;
    localparam logic ACT_READ     = 1'b0;

    logic [15:0]    log_page [PAGE_HW];
    frls_pkg::rsp_t due_rsp [$];
    int             bad_words = 0;
    int             erases    = 0;
    int             seen      = 0;

    // slot of the newest record, -1 when the page holds none
    function automatic int latest_slot();
        for (int k = 0; 3 * k <= PAGE_HW - 4; k++)
        begin
            if (log_page[3 * k] == frls_pkg::REC_MARK
                && log_page[3 * k + 3] != frls_pkg::REC_MARK)
                return k;
        end
        return -1;
    endfunction

    function automatic frls_pkg::rsp_t log_step(frls_pkg::req_t w);
        frls_pkg::rsp_t a;
        int             k;
        int             base;
        a = '0;
        k = latest_slot();
        if (w.action == ACT_READ)
        begin
            if (k >= 0)
            begin
                a.found      = 1'b1;
                a.read_value = {log_page[3 * k + 2], log_page[3 * k + 1]};
            end
        end
        else
        begin
            a.found = 1'b1;
            // no record yet, or the next slot would start at or beyond PAGE_HW - 6
            if (k < 0 || 3 * (k + 1) >= PAGE_HW - 6)
            begin
                a.page_erased = 1'b1;
                foreach (log_page[i])
                    log_page[i] = frls_pkg::ERASED_HW;
                base = 0;
            end
            else
            begin
                base = 3 * (k + 1);
            end
            log_page[base]     = frls_pkg::REC_MARK;
            log_page[base + 1] = w.write_value[15:0];
            log_page[base + 2] = w.write_value[31:16];
        end
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frls_pkg::rsp_t want;
        if (!rst_n)
        begin
            foreach (log_page[i])
                log_page[i] = frls_pkg::ERASED_HW;
            due_rsp.delete();
        end
        else
        begin
            // response side first so a same-edge answer to a new word counts as stray
            if (rsp_valid && !rsp_stall)
            begin
                seen++;
                if (due_rsp.size() == 0)
                begin
                    bad_words++;
                    if (bad_words <= REPORT_LIMIT)
                        $display("unexpected response word %0d: found %b value %h erased %b",
                                 seen, rsp.found, rsp.read_value, rsp.page_erased);
                end
                else
                begin
                    want = due_rsp.pop_front();
                    if (rsp.found !== want.found || rsp.read_value !== want.read_value
                        || rsp.page_erased !== want.page_erased)
                    begin
                        bad_words++;
                        if (bad_words <= REPORT_LIMIT)
                            $display("word %0d exp/act: found %b/%b value %h/%h erased %b/%b",
                                     seen, want.found, rsp.found, want.read_value,
                                     rsp.read_value, want.page_erased, rsp.page_erased);
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                want = log_step(req);
                if (want.page_erased)
                    erases++;
                due_rsp.push_back(want);
            end
        end
        mismatches    <= bad_words;
        pending_words <= due_rsp.size();
        erase_count   <= erases;
        words_checked <= seen;
    end

endmodule

>>> sim/tb_flash_record_log_store.sv
`timescale 1ns / 1ps

module tb_flash_record_log_store;

    localparam int   PAGE_HW        = 1024;
    // records a page takes before the next append wraps it
    localparam int   PAGE_RECORDS   = (PAGE_HW - 4) / 3;
    localparam int   RANDOM_WORDS   = 275;
    localparam int   HOLD_CYCLES    = 400;
    localparam int   TAIL_CYCLES    = 32;
    localparam int   CYCLE_LIMIT    = 1_500_000;
    localparam logic ACT_READ       = 1'b0;
    localparam logic ACT_APPEND     = 1'b1;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           req_valid;
    logic           req_stall;
    frls_pkg::req_t req;
    logic           rsp_valid;
    logic           rsp_stall;
    frls_pkg::rsp_t rsp;

    int mismatches;
    int pending_words;
    int erase_count;
    int words_checked;

    int cycles        = 0;
    int appends_sent  = 0;
    int reads_sent    = 0;
    bit quiet         = 1'b0;
    bit send_idle     = 1'b1;
    bit recv_idle     = 1'b1;
    bit hold_off_now  = 1'b0;
    bit hold_off_done = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    flash_record_log_store #(
        .PAGE_HALFWORDS(PAGE_HW)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    frls_log_checker #(
        .PAGE_HW(PAGE_HW)
    ) log_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req          (req),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .rsp          (rsp),
        .mismatches   (mismatches),
        .pending_words(pending_words),
        .erase_count  (erase_count),
        .words_checked(words_checked)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // response side: random stall bursts, one long hold so the block backs up
    initial
    begin
        rsp_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 63) == 0)
                recv_idle = ~recv_idle;
            if (hold_off_now && !hold_off_done)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rsp_stall <= 1'b0;
                hold_off_done = 1'b1;
            end
            else if (!quiet && recv_idle && $urandom_range(0, 3) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    task automatic offer_word(input frls_pkg::req_t w);
        int gap;
        gap = 0;
        if (!quiet && send_idle && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 16);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (w.action == ACT_APPEND)
            appends_sent++;
        else
            reads_sent++;
    endtask

    initial
    begin
        frls_pkg::req_t opening [$];
        frls_pkg::req_t w;
        int             n_rand;
        bit             last_append;

        req_valid = 1'b0;
        req       = '0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // empty page, value extremes, marker pattern inside the value halves
        opening.push_back('{ACT_READ,   32'hFFFF_FFFF});
        opening.push_back('{ACT_APPEND, 32'h0000_0000});
        opening.push_back('{ACT_READ,   32'h0000_0000});
        opening.push_back('{ACT_APPEND, 32'hFFFF_FFFF});
        opening.push_back('{ACT_READ,   32'h5A5A_A5A5});
        opening.push_back('{ACT_APPEND, 32'hAAAA_AAAA});
        opening.push_back('{ACT_READ,   32'h0000_0000});
        opening.push_back('{ACT_APPEND, 32'h0000_AAAA});
        opening.push_back('{ACT_READ,   32'hFFFF_FFFF});
        opening.push_back('{ACT_APPEND, 32'hAAAA_0000});
        opening.push_back('{ACT_READ,   32'h0000_0000});
        opening.push_back('{ACT_APPEND, 32'h8000_0001});
        opening.push_back('{ACT_APPEND, 32'h7FFE_FFFF});
        opening.push_back('{ACT_READ,   32'h1234_5678});
        opening.push_back('{ACT_READ,   32'h0000_0000});
        foreach (opening[i])
            offer_word(opening[i]);

        // mostly appends so the scan runs deep into the page
        n_rand      = 0;
        last_append = 1'b0;
        while (n_rand < RANDOM_WORDS)
        begin
            if (n_rand % 30 == 0)
                send_idle = ($urandom_range(0, 2) != 0);
            quiet = (n_rand >= RANDOM_WORDS - 40);
            if (n_rand == 40)
                hold_off_now = 1'b1;
            w.action = ($urandom_range(0, 7) == 0) ? ACT_READ : ACT_APPEND;
            // read back right after an append that wrapped the page
            if (last_append && appends_sent % PAGE_RECORDS == 1)
                w.action = ACT_READ;
            case ($urandom_range(0, 9))
                0:       w.write_value = 32'h0000_0000;
                1:       w.write_value = 32'hFFFF_FFFF;
                2:       w.write_value = {frls_pkg::REC_MARK, 16'($urandom)};
                3:       w.write_value = {16'($urandom), frls_pkg::REC_MARK};
                default: w.write_value = $urandom;
            endcase
            offer_word(w);
            last_append = (w.action == ACT_APPEND);
            n_rand++;
        end

        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d requests sent (%0d appends, %0d reads), %0d responses checked",
                 appends_sent + reads_sent, appends_sent, reads_sent, words_checked);
        $display("%0d appends erased the page, one %0d-cycle output hold under load",
                 erase_count, HOLD_CYCLES);
        if (mismatches == 0 && pending_words == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
